/* design/ips_pkg.sv */
// ----------------------------------------------------------------------------
// ips_pkg
// Types, codes and constants shared by the IMU bus poll sequencer.
// ----------------------------------------------------------------------------
package ips_pkg;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_DONE = 2'd1,
        OP_DATA = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ACT_WRITE   = 3'd0,
        ACT_POINTER = 3'd1,
        ACT_READ    = 3'd2,
        ACT_REPORT  = 3'd3,
        ACT_FAULT   = 3'd4
    } action_t;

    // configuration register indexes
    localparam logic [2:0] CFG_ACCEL_DEVICE      = 3'd0;
    localparam logic [2:0] CFG_MAG_DEVICE        = 3'd1;
    localparam logic [2:0] CFG_GYRO_DEVICE       = 3'd2;
    localparam logic [2:0] CFG_GYRO_CONTROL_REG  = 3'd3;
    localparam logic [2:0] CFG_GYRO_OUTPUT_REG   = 3'd4;
    localparam logic [2:0] CFG_ACCEL_POWER_VALUE = 3'd5;
    localparam logic [2:0] CFG_MAG_RATE_VALUE    = 3'd6;
    localparam logic [2:0] CFG_GYRO_POWER_VALUE  = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    // configuration reset values
    localparam logic [6:0] RST_ACCEL_DEVICE      = 7'h18;
    localparam logic [6:0] RST_MAG_DEVICE        = 7'h1E;
    localparam logic [6:0] RST_GYRO_DEVICE       = 7'h69;
    localparam logic [7:0] RST_GYRO_CONTROL_REG  = 8'h20;
    localparam logic [7:0] RST_GYRO_OUTPUT_REG   = 8'h28;
    localparam logic [7:0] RST_ACCEL_POWER_VALUE = 8'h27;
    localparam logic [7:0] RST_MAG_RATE_VALUE    = 8'h14;
    localparam logic [7:0] RST_GYRO_POWER_VALUE  = 8'h0F;

    // chip register addresses
    localparam logic [7:0] ACCEL_CTRL1_ADDR = 8'h20;
    localparam logic [7:0] ACCEL_CTRL4_ADDR = 8'h23;
    localparam logic [7:0] ACCEL_OUT_ADDR   = 8'h28;
    localparam logic [7:0] MAG_RATE_ADDR    = 8'h00;
    localparam logic [7:0] MAG_MODE_ADDR    = 8'h02;
    localparam logic [7:0] MAG_OUT_ADDR     = 8'h03;
    localparam logic [7:0] AUTO_INC_BIT     = 8'h80;

    typedef struct packed {
        logic [6:0] accel_device;
        logic [6:0] mag_device;
        logic [6:0] gyro_device;
        logic [7:0] gyro_control_reg;
        logic [7:0] gyro_output_reg;
        logic [7:0] accel_power_value;
        logic [7:0] mag_rate_value;
        logic [7:0] gyro_power_value;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [47:0] read_bytes;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [6:0]  device_addr;
        logic [7:0]  reg_addr;
        logic [7:0]  reg_value;
        logic [47:0] mag_words;
        logic [47:0] accel_words;
        logic [47:0] gyro_words;
    } out_item_t;

endpackage

/* design/ips_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ips_cfg_regs
// Configuration register file: device addresses, register addresses and
// init values, loaded through the configuration write channel.
// ----------------------------------------------------------------------------
module ips_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_en,
    input  logic [ips_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  logic [ips_pkg::CFG_DATA_W-1:0]    wr_data,
    output ips_pkg::cfg_t                     cfg
);

    ips_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.accel_device      <= ips_pkg::RST_ACCEL_DEVICE;
            cfg_reg.mag_device        <= ips_pkg::RST_MAG_DEVICE;
            cfg_reg.gyro_device       <= ips_pkg::RST_GYRO_DEVICE;
            cfg_reg.gyro_control_reg  <= ips_pkg::RST_GYRO_CONTROL_REG;
            cfg_reg.gyro_output_reg   <= ips_pkg::RST_GYRO_OUTPUT_REG;
            cfg_reg.accel_power_value <= ips_pkg::RST_ACCEL_POWER_VALUE;
            cfg_reg.mag_rate_value    <= ips_pkg::RST_MAG_RATE_VALUE;
            cfg_reg.gyro_power_value  <= ips_pkg::RST_GYRO_POWER_VALUE;
        end else if (wr_en) begin
            case (wr_index)
                ips_pkg::CFG_ACCEL_DEVICE:      cfg_reg.accel_device      <= wr_data[6:0];
                ips_pkg::CFG_MAG_DEVICE:        cfg_reg.mag_device        <= wr_data[6:0];
                ips_pkg::CFG_GYRO_DEVICE:       cfg_reg.gyro_device       <= wr_data[6:0];
                ips_pkg::CFG_GYRO_CONTROL_REG:  cfg_reg.gyro_control_reg  <= wr_data;
                ips_pkg::CFG_GYRO_OUTPUT_REG:   cfg_reg.gyro_output_reg   <= wr_data;
                ips_pkg::CFG_ACCEL_POWER_VALUE: cfg_reg.accel_power_value <= wr_data;
                ips_pkg::CFG_MAG_RATE_VALUE:    cfg_reg.mag_rate_value    <= wr_data;
                ips_pkg::CFG_GYRO_POWER_VALUE:  cfg_reg.gyro_power_value  <= wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/ips_core.sv */
// ----------------------------------------------------------------------------
// ips_core
// Sequencer state (step, sample stores, fault flag) and the single-pass
// logic that turns one event into at most one bus action, report or fault.
// ----------------------------------------------------------------------------
module ips_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  ips_pkg::in_item_t   item,
    input  ips_pkg::cfg_t       cfg,
    output logic                has_result,
    output ips_pkg::out_item_t  result
);

    typedef enum logic [3:0] {
        ST_ACCEL_CTRL1 = 4'd0,
        ST_ACCEL_CTRL4 = 4'd1,
        ST_MAG_RATE    = 4'd2,
        ST_MAG_MODE    = 4'd3,
        ST_GYRO_CTRL   = 4'd4,
        ST_MAG_PTR     = 4'd5,
        ST_MAG_READ    = 4'd6,
        ST_ACCEL_PTR   = 4'd7,
        ST_ACCEL_READ  = 4'd8,
        ST_GYRO_PTR    = 4'd9,
        ST_GYRO_READ   = 4'd10,
        ST_REPORT      = 4'd11
    } step_t;

    step_t       step_reg, step_next;
    logic [47:0] mag_reg, mag_next;
    logic [47:0] accel_reg, accel_next;
    logic [47:0] gyro_reg, gyro_next;
    logic        faulted_reg, faulted_next;
    logic        data_bad;

    function automatic logic [47:0] swap_pairs(input logic [47:0] b);
        logic [47:0] r;
        for (int k = 0; k < 3; k++) begin
            r[16*k +: 16] = {b[16*k +: 8], b[16*k+8 +: 8]};
        end
        return r;
    endfunction

    assign has_result = (ips_pkg::op_t'(item.operation) != ips_pkg::OP_NONE);

    always_comb begin
        step_next    = step_reg;
        mag_next     = mag_reg;
        accel_next   = accel_reg;
        gyro_next    = gyro_reg;
        faulted_next = faulted_reg;
        data_bad     = 1'b0;
        result       = '0;

        if (!has_result) begin
            result = '0;
        end else if (faulted_reg) begin
            result.action = ips_pkg::ACT_FAULT;
        end else begin
            if (ips_pkg::op_t'(item.operation) == ips_pkg::OP_DATA) begin
                case (step_reg)
                    ST_ACCEL_PTR: mag_next   = swap_pairs(item.read_bytes);
                    ST_GYRO_PTR:  accel_next = item.read_bytes;
                    ST_REPORT:    gyro_next  = item.read_bytes;
                    default:      data_bad   = 1'b1;
                endcase
            end
            if (data_bad) begin
                faulted_next  = 1'b1;
                result.action = ips_pkg::ACT_FAULT;
            end else begin
                step_next = step_t'(step_reg + 4'd1);
                case (step_reg)
                    ST_ACCEL_CTRL1: begin
                        result.action      = ips_pkg::ACT_WRITE;
                        result.device_addr = cfg.accel_device;
                        result.reg_addr    = ips_pkg::ACCEL_CTRL1_ADDR;
                        result.reg_value   = cfg.accel_power_value;
                    end
                    ST_ACCEL_CTRL4: begin
                        result.action      = ips_pkg::ACT_WRITE;
                        result.device_addr = cfg.accel_device;
                        result.reg_addr    = ips_pkg::ACCEL_CTRL4_ADDR;
                    end
                    ST_MAG_RATE: begin
                        result.action      = ips_pkg::ACT_WRITE;
                        result.device_addr = cfg.mag_device;
                        result.reg_addr    = ips_pkg::MAG_RATE_ADDR;
                        result.reg_value   = cfg.mag_rate_value;
                    end
                    ST_MAG_MODE: begin
                        result.action      = ips_pkg::ACT_WRITE;
                        result.device_addr = cfg.mag_device;
                        result.reg_addr    = ips_pkg::MAG_MODE_ADDR;
                    end
                    ST_GYRO_CTRL: begin
                        result.action      = ips_pkg::ACT_WRITE;
                        result.device_addr = cfg.gyro_device;
                        result.reg_addr    = cfg.gyro_control_reg;
                        result.reg_value   = cfg.gyro_power_value;
                    end
                    ST_MAG_PTR: begin
                        result.action      = ips_pkg::ACT_POINTER;
                        result.device_addr = cfg.mag_device;
                        result.reg_addr    = ips_pkg::MAG_OUT_ADDR;
                    end
                    ST_MAG_READ: begin
                        result.action      = ips_pkg::ACT_READ;
                        result.device_addr = cfg.mag_device;
                    end
                    ST_ACCEL_PTR: begin
                        result.action      = ips_pkg::ACT_POINTER;
                        result.device_addr = cfg.accel_device;
                        result.reg_addr    = ips_pkg::ACCEL_OUT_ADDR | ips_pkg::AUTO_INC_BIT;
                    end
                    ST_ACCEL_READ: begin
                        result.action      = ips_pkg::ACT_READ;
                        result.device_addr = cfg.accel_device;
                    end
                    ST_GYRO_PTR: begin
                        result.action      = ips_pkg::ACT_POINTER;
                        result.device_addr = cfg.gyro_device;
                        result.reg_addr    = cfg.gyro_output_reg | ips_pkg::AUTO_INC_BIT;
                    end
                    ST_GYRO_READ: begin
                        result.action      = ips_pkg::ACT_READ;
                        result.device_addr = cfg.gyro_device;
                    end
                    default: begin
                        // report, also covers the unused step codes
                        result.action      = ips_pkg::ACT_REPORT;
                        result.mag_words   = mag_next;
                        result.accel_words = accel_next;
                        result.gyro_words  = gyro_next;
                        step_next          = ST_MAG_PTR;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= ST_ACCEL_CTRL1;
            mag_reg     <= '0;
            accel_reg   <= '0;
            gyro_reg    <= '0;
            faulted_reg <= 1'b0;
        end else if (fire) begin
            step_reg    <= step_next;
            mag_reg     <= mag_next;
            accel_reg   <= accel_next;
            gyro_reg    <= gyro_next;
            faulted_reg <= faulted_next;
        end
    end

`ifndef SYNTH
    a_fault_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        faulted_reg |=> faulted_reg)
        else $error("fault flag cleared without reset");

    a_report_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && has_result && result.action == ips_pkg::ACT_REPORT |=> step_reg == ST_MAG_PTR)
        else $error("report did not return to magnetometer pointer step");

    a_bad_data_faults: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !faulted_reg && ips_pkg::op_t'(item.operation) == ips_pkg::OP_DATA
        && step_reg != ST_ACCEL_PTR && step_reg != ST_GYRO_PTR && step_reg != ST_REPORT
        |=> faulted_reg && $stable(step_reg))
        else $error("misplaced data did not raise fault");

    a_fault_holds_step: assert property (@(posedge aclk) disable iff (!aresetn)
        faulted_reg |=> $stable(step_reg) && $stable(gyro_reg))
        else $error("state changed while faulted");
`endif

endmodule

/* design/imu_i2c_poll_sequencer.sv */
// ----------------------------------------------------------------------------
// imu_i2c_poll_sequencer
// Init and polling sequencer for a three-chip IMU on a two-wire bus.
// ----------------------------------------------------------------------------
// Datapath: each input transaction is held in an input register, then its
// result is registered in a result register.
// Throughput: one event per cycle while m_ready does not stall a held result;
// the result register refills in the cycle it is drained.
// Reset: synchronous active low; config returns to defaults, step to the
// first init write, sample stores and fault flag to zero.
module imu_i2c_poll_sequencer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ips_pkg::in_item_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ips_pkg::out_item_t                m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ips_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ips_pkg::CFG_DATA_W-1:0]    cfg_data
);

    ips_pkg::cfg_t      cfg;
    ips_pkg::in_item_t  in_data_reg;
    ips_pkg::out_item_t out_data_reg;
    ips_pkg::out_item_t result;
    logic               in_valid_reg;
    logic               out_valid_reg, out_valid_next;
    logic               has_result;
    logic               advance;

    assign cfg_ready = 1'b1;

    ips_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ips_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (advance),
        .item       (in_data_reg),
        .cfg        (cfg),
        .has_result (has_result),
        .result     (result)
    );

    assign advance = in_valid_reg && (!has_result || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && has_result) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance && has_result) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTH
    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("pending result transaction overwritten");
`endif

endmodule
